>>> design/tbp_pkg.sv
package tbp_pkg;

    localparam int FLOW_COUNT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 24;

    localparam int FLOW_IN_W = 8;
    localparam int TIME_W    = 48;
    localparam int SEC_W     = 39;
    localparam int TOKEN_W   = 16;
    localparam int RATE_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd83886;
    localparam logic [TOKEN_W-1:0] BURST_RESET = 16'd100;

    // seconds divider: one byte of the millisecond count per step
    localparam int MS_PER_S  = 1000;
    localparam int REM_W     = $clog2(MS_PER_S);
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = TIME_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int MOD_ENTRIES = 1 << FLOW_IN_W;
    localparam int MOD_VAL_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFILL_RATE = 1'b0,
        CFG_BURST_SIZE  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [DIV_BITS-1:0] quo;
    } t_div_step;

    typedef logic [MOD_ENTRIES-1:0][MOD_VAL_W-1:0] t_mod_table;

    // restoring division by one second, DIV_BITS bits of the dividend per call
    function automatic t_div_step div_step(input logic [REM_W-1:0] rem,
                                           input logic [DIV_BITS-1:0] digits);
        t_div_step        res;
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] r;
        r = rem;
        res.quo = '0;
        for (int b = DIV_BITS - 1; b >= 0; b--) begin
            trial = {r, digits[b]};
            if (trial >= (REM_W + 1)'(MS_PER_S)) begin
                r = REM_W'(trial - (REM_W + 1)'(MS_PER_S));
                res.quo[b] = 1'b1;
            end else begin
                r = trial[REM_W-1:0];
            end
        end
        res.rem = r;
        return res;
    endfunction

    // flow index wrap, worked out once at elaboration by repeated subtraction
    function automatic t_mod_table mod_table(input int unsigned n);
        t_mod_table  tbl;
        int unsigned r;
        for (int i = 0; i < MOD_ENTRIES; i++) begin
            r = i;
            for (int k = 0; k < MOD_ENTRIES; k++) begin
                if (r >= n) begin
                    r = r - n;
                end
            end
            tbl[i] = MOD_VAL_W'(r);
        end
        return tbl;
    endfunction

endpackage

>>> design/tbp_queue.sv
module tbp_queue
    import tbp_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> design/tbp_front.sv
module tbp_front
    import tbp_pkg::*;
#(
    parameter int FLOW_COUNT = FLOW_COUNT_DEF,
    localparam int FW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1,
    localparam int QW = FW + TIME_W + SEC_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FLOW_IN_W-1:0] i_flow_index,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_clearing,
    output logic                 o_push,
    output logic [QW-1:0]        o_push_data,
    input  logic                 i_full
);

    localparam t_mod_table MOD_TABLE = mod_table(FLOW_COUNT);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state         r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [FW-1:0]        r_flow;
    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_num;
    logic [TIME_W-1:0]    r_quo;
    logic [REM_W-1:0]     r_rem;
    logic                 accept;
    t_div_step            step;

    assign o_in_stall  = (r_state != F_IDLE) || i_clearing;
    assign accept      = i_in_valid && !o_in_stall;
    assign step        = div_step(r_rem, r_num[TIME_W-1 -: DIV_BITS]);
    assign o_push      = (r_state == F_PUSH);
    assign o_push_data = {r_flow, r_now, r_quo[SEC_W-1:0]};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            F_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flow <= MOD_TABLE[i_flow_index][FW-1:0];
            r_now  <= i_now_ms;
            r_num  <= i_now_ms;
            r_quo  <= '0;
            r_rem  <= '0;
        end else if (r_state == F_DIV) begin
            r_num <= r_num << DIV_BITS;
            r_quo <= {r_quo[TIME_W-DIV_BITS-1:0], step.quo};
            r_rem <= step.rem;
        end
    end

endmodule

>>> design/tbp_back.sv
module tbp_back
    import tbp_pkg::*;
#(
    parameter int FLOW_COUNT    = FLOW_COUNT_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF,
    localparam int FW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1,
    localparam int QW = FW + TIME_W + SEC_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_q_valid,
    input  logic [QW-1:0]        i_q_data,
    output logic                 o_q_pop,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_allowed,
    output logic [TOKEN_W-1:0]   o_tokens_left,
    output logic [SEC_W-1:0]     o_reset_seconds
);

    localparam int LW     = TOKEN_W + FRACTION_BITS;
    localparam int EW     = 1 + LW + TIME_W;
    localparam int LO_W   = 2 * RATE_W;
    localparam int HI_W   = (TIME_W - RATE_W) + RATE_W;
    localparam int FULL_W = TIME_W + RATE_W;

    typedef enum logic [7:0] {
        B_CLEAR  = 8'b0000_0001,
        B_IDLE   = 8'b0000_0010,
        B_ELAPSE = 8'b0000_0100,
        B_MUL_LO = 8'b0000_1000,
        B_MUL_HI = 8'b0001_0000,
        B_SUM    = 8'b0010_0000,
        B_ADD    = 8'b0100_0000,
        B_WRITE  = 8'b1000_0000
    } t_back_state;

    t_back_state        r_state, n_state;
    logic [FW-1:0]      r_clr_idx;
    logic [RATE_W-1:0]  r_rate;
    logic [TOKEN_W-1:0] r_burst;

    logic [EW-1:0]      r_mem [FLOW_COUNT];
    logic [EW-1:0]      r_rd_data;

    logic [FW-1:0]      r_flow;
    logic [TIME_W-1:0]  r_now;
    logic [SEC_W-1:0]   r_secs;
    logic [TIME_W-1:0]  r_elapsed;
    logic [LW-1:0]      r_level;
    logic [LO_W-1:0]    r_prod_lo;
    logic [HI_W-1:0]    r_prod_hi;
    logic [LW-1:0]      r_add;
    logic               r_over;

    logic [FW-1:0]      head_flow;
    logic [TIME_W-1:0]  head_now;
    logic [SEC_W-1:0]   head_secs;
    logic               rd_known;
    logic [LW-1:0]      rd_level;
    logic [TIME_W-1:0]  rd_last;
    logic [LW-1:0]      cap;
    logic [LW-1:0]      one;
    logic [FULL_W-1:0]  full;
    logic [LW:0]        sum;
    logic               out_free;
    logic               finish;
    logic               allow;
    logic [LW-1:0]      level_after;
    logic               wr_en;
    logic [FW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;

    assign {head_flow, head_now, head_secs} = i_q_data;
    assign {rd_known, rd_level, rd_last}    = r_rd_data;

    assign cap  = LW'(r_burst) << FRACTION_BITS;
    assign one  = LW'(1) << FRACTION_BITS;
    assign full = {r_prod_hi, {RATE_W{1'b0}}} + FULL_W'(r_prod_lo);
    assign sum  = {1'b0, r_level} + {1'b0, r_add};

    assign o_cfg_ready = 1'b1;
    assign o_clearing  = (r_state == B_CLEAR);
    assign o_q_pop     = (r_state == B_IDLE) && i_q_valid;
    assign out_free    = !o_out_valid || !i_out_stall;
    assign finish      = (r_state == B_WRITE) && out_free;

    assign allow       = (r_level >= one);
    assign level_after = allow ? r_level - one : r_level;

    assign wr_en   = o_clearing || finish;
    assign wr_addr = o_clearing ? r_clr_idx : r_flow;
    assign wr_data = o_clearing ? '0 : {1'b1, level_after, r_now};

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (r_clr_idx == FW'(FLOW_COUNT - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    n_state = B_ELAPSE;
                end
            end
            B_ELAPSE: n_state = B_MUL_LO;
            B_MUL_LO: n_state = B_MUL_HI;
            B_MUL_HI: n_state = B_SUM;
            B_SUM:    n_state = B_ADD;
            B_ADD:    n_state = B_WRITE;
            B_WRITE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_idx   <= '0;
            r_rate      <= RATE_RESET;
            r_burst     <= BURST_RESET;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_REFILL_RATE: r_rate  <= i_cfg_data[RATE_W-1:0];
                    CFG_BURST_SIZE:  r_burst <= i_cfg_data[TOKEN_W-1:0];
                    default: ;
                endcase
            end
            if (finish) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // flow table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[head_flow];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_flow <= head_flow;
                r_now  <= head_now;
                r_secs <= head_secs;
            end
            B_ELAPSE: begin
                r_elapsed <= (r_now > rd_last) ? r_now - rd_last : '0;
                // a new flow starts full; the refill then clamps at capacity
                r_level   <= rd_known ? rd_level : cap;
            end
            B_MUL_LO: r_prod_lo <= r_elapsed[RATE_W-1:0] * r_rate;
            B_MUL_HI: r_prod_hi <= r_elapsed[TIME_W-1:RATE_W] * r_rate;
            B_SUM: begin
                r_over <= ((full >> LW) != '0);
                r_add  <= full[LW-1:0];
            end
            B_ADD: begin
                if (r_over || (sum > {1'b0, cap})) begin
                    r_level <= cap;
                end else begin
                    r_level <= sum[LW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_allowed       <= allow;
            o_tokens_left   <= level_after[LW-1:FRACTION_BITS];
            o_reset_seconds <= allow ? r_secs : r_secs + 1'b1;
        end
    end

endmodule

>>> design/token_bucket_policer_unit.sv
// channel | direction | handshake                 | beat
// --------+-----------+---------------------------+---------------------------------------
// in      | input     | i_in_valid / o_in_stall   | i_flow_index, i_now_ms
// out     | output    | o_out_valid / i_out_stall | o_allowed, o_tokens_left, o_reset_seconds
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each request passes through the flow-table sequencer (read, elapsed time, two partial
// products, sum, refill clamp, write back) and the front (accept, six divide steps,
// hand-off to a two-entry queue); the front takes a new request only after its hand-off.
// After reset every flow table entry is swept clear; o_in_stall stays high meanwhile.
// A stalled result holds in the output register while the front keeps taking requests until the queue fills.
module token_bucket_policer_unit
    import tbp_pkg::*;
#(
    parameter int FLOW_COUNT    = FLOW_COUNT_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FLOW_IN_W-1:0] i_flow_index,
    input  logic [TIME_W-1:0]    i_now_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_allowed,
    output logic [TOKEN_W-1:0]   o_tokens_left,
    output logic [SEC_W-1:0]     o_reset_seconds,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int FW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
    localparam int QW = FW + TIME_W + SEC_W;

    logic          clearing;
    logic          push;
    logic [QW-1:0] push_data;
    logic          q_full;
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          q_pop;

    tbp_front #(
        .FLOW_COUNT (FLOW_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_flow_index (i_flow_index),
        .i_now_ms     (i_now_ms),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_full       (q_full)
    );

    tbp_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    tbp_back #(
        .FLOW_COUNT    (FLOW_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_allowed       (o_allowed),
        .o_tokens_left   (o_tokens_left),
        .o_reset_seconds (o_reset_seconds)
    );

endmodule

>>> design/tbp_checker.sv
module tbp_checker
    import tbp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_allowed,
    input logic [TOKEN_W-1:0]   o_tokens_left,
    input logic [SEC_W-1:0]     o_reset_seconds
);

    // the flow table sweep holds off requests right after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during flow table sweep");

    // one request in the front at a time
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while the first is still being split");

    // a denied request leaves less than one whole token
    a_denied_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_allowed |-> o_tokens_left == '0)
        else $error("denied result reports whole tokens left");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_allowed) && $stable(o_tokens_left)
            && $stable(o_reset_seconds))
        else $error("stalled result changed");

endmodule

bind token_bucket_policer_unit tbp_checker u_tbp_checker (.*);
